// ===== rtl/utpb_pkg.sv =====
// Shared types, constants and helper functions for the underwater tint pixel blend.
// Holds the pixel structs, CSR register indexes, reciprocal constants and the root table.
// No dependencies; every other file imports this package.
package utpb_pkg;

   // Number of color channels and register stages in one soft-light unit
   localparam int CHANNELS  = 3;
   localparam int SL_STAGES = 5;

   // CSR register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_HUE_CH0 = 2'd0;
   localparam csr_index_type CSR_HUE_CH1 = 2'd1;
   localparam csr_index_type CSR_HUE_CH2 = 2'd2;

   localparam logic [7:0] HUE_CH0_RESET = 8'd1;
   localparam logic [7:0] HUE_CH1_RESET = 8'd68;
   localparam logic [7:0] HUE_CH2_RESET = 8'd36;

   // floor(x / 255) = (x * RECIP) >> SHIFT, exact over the stated input width
   localparam logic [24:0] RECIP255_W24 = 25'd16843010;   // x < 2^24, shift 32
   localparam logic [17:0] RECIP255_W17 = 18'd131587;     // x < 2^17, shift 25

   // Rounding offsets
   localparam logic [14:0] DARK_ROUND  = 15'd32512;       // half of 255 * 255, rounded down
   localparam logic [15:0] LIGHT_ROUND = 16'd32768;       // half of 2^16
   localparam logic [6:0]  MUL_ROUND   = 7'd127;

   typedef struct packed {
      logic [7:0] base_c0;
      logic [7:0] base_c1;
      logic [7:0] base_c2;
      logic [7:0] mask_c0;
      logic [7:0] mask_c1;
      logic [7:0] mask_c2;
      logic [7:0] noise_gray;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] out_c0;
      logic [7:0] out_c1;
      logic [7:0] out_c2;
   } pixel_out_type;

   typedef logic [15:0] root_table_type [256];

   // Q0.16 square root of a / 255, capped at the top code
   function automatic root_table_type build_root_table();
      root_table_type  tbl;
      longint unsigned v;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      for (int idx = 0; idx < 256; idx++) begin
         v  = (64'(idx) << 32) / 255;
         lo = 0;
         hi = 65536;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         if (lo > 65535) begin
            lo = 65535;
         end
         tbl[idx] = 16'(lo);
      end
      return tbl;
   endfunction

   localparam root_table_type ROOT_TABLE = build_root_table();

   // floor(x / 255) for a 17-bit value
   function automatic logic [8:0] div255_w17(input logic [16:0] x);
      logic [34:0] prod;
      prod = 35'(x) * 35'(RECIP255_W17);
      return prod[33:25];
   endfunction

endpackage

// ===== rtl/utpb_soft_light.sv =====
// Five-stage pipelined soft-light blend of a base byte with a layer byte.
// Depends on utpb_pkg for the root table and the divide-by-255 constants.
module utpb_soft_light (
   input  logic       clock,
   input  logic [7:0] a,
   input  logic [7:0] b,
   output logic [7:0] result
);
   import utpb_pkg::*;

   // stage 0: first products and root lookup
   logic [7:0]  s0_a_ff;
   logic [6:0]  s0_b_ff;
   logic        s0_dark_ff;
   logic [15:0] s0_t_ff;
   logic [16:0] s0_u_ff;
   logic [15:0] s0_root_ff;
   logic [7:0]  s0_c_ff;
   logic [15:0] s0_t_in;
   logic [15:0] s0_ub_in;

   // stage 1
   logic [7:0]  s1_a_ff;
   logic        s1_dark_ff;
   logic [16:0] s1_m_ff;
   logic [16:0] s1_u_ff;
   logic [23:0] s1_w_ff;
   logic [16:0] s1_m_in;
   logic [23:0] s1_w_in;

   // stage 2
   logic        s2_dark_ff;
   logic [23:0] s2_n_ff;
   logic [16:0] s2_y_ff;
   logic [24:0] s2_n_prod;
   logic [31:0] s2_p_base;
   logic [31:0] s2_p_scaled;
   logic [16:0] s2_y_in;

   // stage 3
   logic        s3_dark_ff;
   logic [15:0] s3_q1_ff;
   logic [8:0]  s3_light_ff;
   logic [23:0] s3_x;
   logic [48:0] s3_q1_prod;
   logic [8:0]  s3_light_in;

   // stage 4
   logic [8:0]  s4_dark_full;
   logic [7:0]  s4_light_sat;
   logic [7:0]  result_ff;

   // a * (255 - 2b) for a dark layer, a * (255 - b) for the light term
   always_comb begin
      s0_t_in  = 16'(a) * 16'({~b[6:0], 1'b1});
      s0_ub_in = 16'(a) * 16'(8'd255 - b);
   end

   always_ff @(posedge clock) begin
      s0_a_ff    <= a;
      s0_b_ff    <= b[6:0];
      s0_dark_ff <= ~b[7];
      s0_t_ff    <= s0_t_in;
      s0_u_ff    <= {s0_ub_in, 1'b0};
      s0_root_ff <= ROOT_TABLE[a];
      s0_c_ff    <= {b[6:0], 1'b1};                      // 2b - 255 for a light layer
   end

   always_comb begin
      s1_m_in = 17'(s0_b_ff) * 17'd510 + 17'(s0_t_ff);
      s1_w_in = 24'(s0_root_ff) * 24'(s0_c_ff);
   end

   always_ff @(posedge clock) begin
      s1_a_ff    <= s0_a_ff;
      s1_dark_ff <= s0_dark_ff;
      s1_m_ff    <= s1_m_in;
      s1_u_ff    <= s0_u_ff;
      s1_w_ff    <= s1_w_in;
   end

   // dark: n = a * m; light: fold the root term down by 2^16 with rounding
   always_comb begin
      s2_n_prod   = 25'(s1_a_ff) * 25'(s1_m_ff);
      s2_p_base   = 32'(s1_w_ff) + 32'(LIGHT_ROUND);
      s2_p_scaled = (s2_p_base << 8) - s2_p_base;
      s2_y_in     = s1_u_ff + 17'(s2_p_scaled[31:16]);
   end

   always_ff @(posedge clock) begin
      s2_dark_ff <= s1_dark_ff;
      s2_n_ff    <= s2_n_prod[23:0];
      s2_y_ff    <= s2_y_in;
   end

   always_comb begin
      s3_x        = s2_n_ff + 24'(DARK_ROUND);
      s3_q1_prod  = 49'(s3_x) * 49'(RECIP255_W24);
      s3_light_in = div255_w17(s2_y_ff);
   end

   always_ff @(posedge clock) begin
      s3_dark_ff  <= s2_dark_ff;
      s3_q1_ff    <= s3_q1_prod[47:32];
      s3_light_ff <= s3_light_in;
   end

   // second divide by 255 for the dark path, saturate the light path
   always_comb begin
      s4_dark_full = div255_w17({1'b0, s3_q1_ff});
      s4_light_sat = s3_light_ff[8] ? 8'hFF : s3_light_ff[7:0];
   end

   always_ff @(posedge clock) begin
      result_ff <= s3_dark_ff ? s4_dark_full[7:0] : s4_light_sat;
   end

   assign result = result_ff;

endmodule

// ===== rtl/underwater_tint_pixel_blend.sv =====
// Top level of the underwater tint pixel blend: CSRs, input register, blend pipeline.
// Depends on utpb_pkg and instantiates utpb_soft_light six times.
//
// Usage:
//  - Input channel: drive req_data and raise start; the pixel transfers at the rising
//    edge where start is high and busy is low. busy is low at all times outside reset,
//    so one pixel can transfer on every clock.
//  - Result channel: rsp_strobe is high for exactly one cycle with rsp_data; the
//    receiver takes it at the edge that ends that cycle and cannot hold it off.
//  - Throughput: one pixel per clock, as every stage is a register and a new pixel
//    enters each cycle. The path per channel is an input register, two five-stage
//    soft-light units, a mask multiply and the divide-by-255 output stage.
//  - CSR port: csr_we, csr_index and csr_wdata write one hue register per edge, with
//    no wait state. Write only while no pixel is in flight. Unknown indexes are dropped.
//  - Reset (synchronous, active high): clears every valid bit, so nothing in flight
//    comes out, and loads the hue registers with their defaults. busy is high
//    while reset is asserted.
module underwater_tint_pixel_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  utpb_pkg::pixel_in_type  req_data,
   output logic                    rsp_strobe,
   output utpb_pkg::pixel_out_type rsp_data,
   input  logic                    csr_we,
   input  utpb_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_wdata
);
   import utpb_pkg::*;

   localparam int MASK_DELAY = 2 * SL_STAGES;

   logic [7:0]               hue_ff [CHANNELS];

   logic                     in_valid_ff;
   pixel_in_type             in_data_ff;

   logic [7:0]               base_w  [CHANNELS];
   logic [CHANNELS-1:0][7:0] mask_w;
   logic [7:0]               tint_w  [CHANNELS];
   logic [7:0]               grain_w [CHANNELS];

   // noise and mask travel beside the soft-light units
   logic [7:0]               noise_dly_ff [SL_STAGES];
   logic [CHANNELS-1:0][7:0] mask_dly_ff  [MASK_DELAY];
   logic                     sl_valid_ff  [MASK_DELAY];

   logic [15:0]              prod_ff [CHANNELS];
   logic                     prod_valid_ff;
   logic [8:0]               out_w   [CHANNELS];

   logic                     rsp_strobe_ff;
   pixel_out_type            rsp_data_ff;

   // No transfers while reset holds the pipeline
   assign busy = reset;

   // CSR writes; drop writes to indexes past the hue registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_ff[0] <= HUE_CH0_RESET;
         hue_ff[1] <= HUE_CH1_RESET;
         hue_ff[2] <= HUE_CH2_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HUE_CH0: hue_ff[0] <= csr_wdata;
            CSR_HUE_CH1: hue_ff[1] <= csr_wdata;
            CSR_HUE_CH2: hue_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register: capture each transferred pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= req_data;
   end

   always_comb begin
      base_w[0] = in_data_ff.base_c0;
      base_w[1] = in_data_ff.base_c1;
      base_w[2] = in_data_ff.base_c2;
      mask_w    = {in_data_ff.mask_c2, in_data_ff.mask_c1, in_data_ff.mask_c0};
   end

   // Side delay lines: noise meets the second blend, mask meets the multiply
   always_ff @(posedge clock) begin
      noise_dly_ff[0] <= in_data_ff.noise_gray;
      for (int i = 1; i < SL_STAGES; i++) begin
         noise_dly_ff[i] <= noise_dly_ff[i-1];
      end
      mask_dly_ff[0] <= mask_w;
      for (int i = 1; i < MASK_DELAY; i++) begin
         mask_dly_ff[i] <= mask_dly_ff[i-1];
      end
   end

   // Valid bits advance in step with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MASK_DELAY; i++) begin
            sl_valid_ff[i] <= 1'b0;
         end
         prod_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         sl_valid_ff[0] <= in_valid_ff;
         for (int i = 1; i < MASK_DELAY; i++) begin
            sl_valid_ff[i] <= sl_valid_ff[i-1];
         end
         prod_valid_ff <= sl_valid_ff[MASK_DELAY-1];
         rsp_strobe_ff <= prod_valid_ff;
      end
   end

   // Per channel: soft light with the hue, then soft light with the noise
   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
      utpb_soft_light u_tint (
         .clock  (clock),
         .a      (base_w[ch]),
         .b      (hue_ff[ch]),
         .result (tint_w[ch])
      );

      utpb_soft_light u_grain (
         .clock  (clock),
         .a      (tint_w[ch]),
         .b      (noise_dly_ff[SL_STAGES-1]),
         .result (grain_w[ch])
      );
   end

   // Mask multiply with rounding, then divide by 255
   always_ff @(posedge clock) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         prod_ff[ch] <= 16'(grain_w[ch]) * 16'(mask_dly_ff[MASK_DELAY-1][ch])
                        + 16'(MUL_ROUND);
      end
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         out_w[ch] = div255_w17({1'b0, prod_ff[ch]});
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.out_c0 <= out_w[0][7:0];
      rsp_data_ff.out_c1 <= out_w[1][7:0];
      rsp_data_ff.out_c2 <= out_w[2][7:0];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
